// ----- design/blm_pkg.sv -----
// ----------------------------------------------------------------------------
// blm_pkg
// Shared types and constants for the battery level monitor.
// ----------------------------------------------------------------------------
package blm_pkg;

    // Default widths of the ADC sample and of the tick counters.
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF  = 8;

    // Width of the band and tick registers.
    localparam int REG_BITS = 8;

    // Register reset values, in ADC counts or ticks.
    localparam int GOOD_LEVEL_RST   = 2792;
    localparam int LOW_LEVEL_RST    = 2528;
    localparam int DEAD_LEVEL_RST   = 2133;
    localparam int HYST_BAND_RST    = 8;
    localparam int HOLD_TICKS_RST   = 18;
    localparam int KEEPON_TICKS_RST = 6;

    // Battery level codes, as shown on the battery_level port.
    typedef enum logic [1:0] {
        LVL_GOOD = 2'd0,
        LVL_LOW  = 2'd1,
        LVL_DEAD = 2'd2
    } level_t;

    // Input item kinds.
    typedef enum logic {
        ACT_TICK    = 1'b0,
        ACT_CONVERT = 1'b1
    } action_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_GOOD_LEVEL   = 3'd0,
        CFG_LOW_LEVEL    = 3'd1,
        CFG_DEAD_LEVEL   = 3'd2,
        CFG_HYST_BAND    = 3'd3,
        CFG_HOLD_TICKS   = 3'd4,
        CFG_KEEPON_TICKS = 3'd5
    } cfg_idx_t;

    // LED pin levels: bit 0 green, bit 1 blue, bit 2 red.
    typedef logic [2:0] led_t;

    localparam led_t LED_OFF      = 3'b000;
    localparam led_t LED_GOOD     = 3'b010;
    localparam led_t LED_LOW      = 3'b101;
    localparam led_t LED_DEAD     = 3'b100;
    localparam led_t LED_CHARGING = 3'b001;

    // LED pattern that shows a battery level.
    function automatic led_t level_leds(input level_t lvl);
        led_t pat;
        unique case (lvl)
            LVL_GOOD: pat = LED_GOOD;
            LVL_LOW:  pat = LED_LOW;
            LVL_DEAD: pat = LED_DEAD;
            default:  pat = LED_DEAD;
        endcase
        return pat;
    endfunction

endpackage

// ----- design/battery_level_monitor.sv -----
// ----------------------------------------------------------------------------
// battery_level_monitor
// Battery level tracker with hysteresis, LED pattern driver and
// manufacturing-mode entry on a long hold of both buttons.
// ----------------------------------------------------------------------------
// Every input beat (a tick or an ADC conversion) produces exactly one result
// beat, which shows in the cycle after it is accepted. The state update is a
// single pass of compare and count logic between the input handshake and the
// result register, so a new beat is accepted in every cycle while the result
// side keeps up; in_ready only drops while a result is held by out_ready low.
// Sustained rate is one beat per clock. Configuration writes take effect at
// the clock edge of the write and should be made while no beat is in flight.
module battery_level_monitor
    import blm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    // Configuration write port.
    input  logic                       cfg_write,
    input  logic [2:0]                 cfg_index,
    input  logic [((SAMPLE_BITS > REG_BITS) ? SAMPLE_BITS : REG_BITS)-1:0] cfg_data,

    // Input channel.
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       action,
    input  logic [SAMPLE_BITS-1:0]     adc_sample,
    input  logic                       charge_mode,
    input  logic                       warning_switch,
    input  logic                       charger_status,
    input  logic                       trigger_button,
    input  logic                       selector_pin,
    input  logic                       audio_idle,

    // Result channel.
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 battery_level,
    output logic                       led_green,
    output logic                       led_blue,
    output logic                       led_red,
    output logic                       start_conversion,
    output logic                       keep_on,
    output logic                       laser_off_pulse,
    output logic                       factory_mode
);

    localparam int CMP_BITS = (COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS;
    localparam int SUM_BITS = SAMPLE_BITS + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration registers.
    logic [SAMPLE_BITS-1:0] good_level_reg;
    logic [SAMPLE_BITS-1:0] low_level_reg;
    logic [SAMPLE_BITS-1:0] dead_level_reg;
    logic [REG_BITS-1:0]    hyst_band_reg;
    logic [REG_BITS-1:0]    hold_ticks_reg;
    logic [REG_BITS-1:0]    keepon_ticks_reg;

    // Monitor state.
    level_t                 level_reg, level_next;
    led_t                   leds_reg, leds_next;
    logic [COUNT_BITS-1:0]  trig_cnt_reg, trig_cnt_next;
    logic [COUNT_BITS-1:0]  sel_cnt_reg, sel_cnt_next;
    logic [COUNT_BITS-1:0]  fact_cnt_reg, fact_cnt_next;
    logic                   factory_reg, factory_next;
    logic                   keep_on_reg, keep_on_next;
    logic                   start_next;
    logic                   laser_next;

    // Result register.
    logic                   out_valid_reg;
    level_t                 res_level_reg;
    led_t                   res_leds_reg;
    logic                   res_start_reg;
    logic                   res_keep_on_reg;
    logic                   res_laser_reg;
    logic                   res_factory_reg;

    // Threshold compare terms.
    logic [SUM_BITS-1:0]    sample_plus_band;
    logic [SUM_BITS-1:0]    good_plus_band;
    logic [SUM_BITS-1:0]    low_plus_band;
    logic                   below_dead;
    logic                   below_good;
    logic                   above_good;
    logic                   above_low;

    // Tick counter terms.
    logic [COUNT_BITS-1:0]  trig_cnt_inc;
    logic [COUNT_BITS-1:0]  sel_cnt_inc;
    logic [COUNT_BITS-1:0]  fact_cnt_inc;
    logic                   hold_done;
    logic                   in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            good_level_reg   <= SAMPLE_BITS'(GOOD_LEVEL_RST);
            low_level_reg    <= SAMPLE_BITS'(LOW_LEVEL_RST);
            dead_level_reg   <= SAMPLE_BITS'(DEAD_LEVEL_RST);
            hyst_band_reg    <= REG_BITS'(HYST_BAND_RST);
            hold_ticks_reg   <= REG_BITS'(HOLD_TICKS_RST);
            keepon_ticks_reg <= REG_BITS'(KEEPON_TICKS_RST);
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GOOD_LEVEL:   good_level_reg   <= cfg_data[SAMPLE_BITS-1:0];
                CFG_LOW_LEVEL:    low_level_reg    <= cfg_data[SAMPLE_BITS-1:0];
                CFG_DEAD_LEVEL:   dead_level_reg   <= cfg_data[SAMPLE_BITS-1:0];
                CFG_HYST_BAND:    hyst_band_reg    <= cfg_data[REG_BITS-1:0];
                CFG_HOLD_TICKS:   hold_ticks_reg   <= cfg_data[REG_BITS-1:0];
                CFG_KEEPON_TICKS: keepon_ticks_reg <= cfg_data[REG_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Threshold compares. For the below compares the band is moved to the sample
    // side so that a threshold below the band never fires without signed arithmetic.
    always_comb
    begin
        sample_plus_band = SUM_BITS'(adc_sample) + SUM_BITS'(hyst_band_reg);
        good_plus_band   = SUM_BITS'(good_level_reg) + SUM_BITS'(hyst_band_reg);
        low_plus_band    = SUM_BITS'(low_level_reg) + SUM_BITS'(hyst_band_reg);
        below_dead       = sample_plus_band < SUM_BITS'(dead_level_reg);
        below_good       = sample_plus_band < SUM_BITS'(good_level_reg);
        above_good       = SUM_BITS'(adc_sample) > good_plus_band;
        above_low        = SUM_BITS'(adc_sample) > low_plus_band;
    end

    // Saturating increments of the tick counters.
    always_comb
    begin
        trig_cnt_inc = (trig_cnt_reg == COUNT_MAX) ? trig_cnt_reg : trig_cnt_reg + 1'b1;
        sel_cnt_inc  = (sel_cnt_reg == COUNT_MAX) ? sel_cnt_reg : sel_cnt_reg + 1'b1;
        fact_cnt_inc = (fact_cnt_reg == COUNT_MAX) ? fact_cnt_reg : fact_cnt_reg + 1'b1;
    end

    // Next state for one input beat.
    always_comb
    begin
        level_next    = level_reg;
        leds_next     = leds_reg;
        trig_cnt_next = trig_cnt_reg;
        sel_cnt_next  = sel_cnt_reg;
        fact_cnt_next = fact_cnt_reg;
        factory_next  = factory_reg;
        keep_on_next  = keep_on_reg;
        start_next    = 1'b0;
        laser_next    = 1'b0;
        hold_done     = 1'b0;

        if (action_t'(action) == ACT_CONVERT)
        begin
            // A conversion moves the level only on a quiet, discharging reading.
            if (audio_idle && !charge_mode)
            begin
                unique case (level_reg)
                    LVL_GOOD:
                    begin
                        if (below_dead)
                        begin
                            level_next = LVL_DEAD;
                            leds_next  = LED_DEAD;
                        end
                        else if (below_good)
                        begin
                            level_next = LVL_LOW;
                            leds_next  = LED_LOW;
                        end
                        else if (above_good)
                        begin
                            leds_next  = LED_GOOD;
                        end
                    end
                    LVL_LOW:
                    begin
                        if (below_dead)
                        begin
                            level_next = LVL_DEAD;
                            leds_next  = LED_DEAD;
                        end
                        else if (above_good)
                        begin
                            level_next = LVL_GOOD;
                            leds_next  = LED_GOOD;
                        end
                    end
                    LVL_DEAD:
                    begin
                        if (above_low)
                        begin
                            level_next = LVL_LOW;
                            leds_next  = LED_LOW;
                        end
                    end
                    default: ;
                endcase
            end
        end
        else
        begin
            // Out of charge/warning mode a tick sets LEDs, may request conversion.
            if (!charge_mode && !warning_switch)
            begin
                if (!charger_status)
                begin
                    leds_next = LED_CHARGING;
                end
                else
                begin
                    leds_next  = level_leds(level_reg);
                    start_next = 1'b1;
                end
            end

            // Button hold counters: trigger is active low, selector active high.
            trig_cnt_next = trigger_button ? '0 : trig_cnt_inc;
            sel_cnt_next  = selector_pin ? sel_cnt_inc : '0;
            hold_done     = (CMP_BITS'(trig_cnt_next) >= CMP_BITS'(hold_ticks_reg)) &&
                            (CMP_BITS'(sel_cnt_next) >= CMP_BITS'(hold_ticks_reg));

            // Manufacturing entry after a long hold of both buttons.
            if (hold_done)
            begin
                level_next    = LVL_LOW;
                leds_next     = LED_LOW;
                keep_on_next  = 1'b1;
                laser_next    = 1'b1;
                factory_next  = 1'b1;
                trig_cnt_next = '0;
                sel_cnt_next  = '0;
            end

            // Manufacturing mode times keep-on off.
            if (factory_next)
            begin
                fact_cnt_next = factory_reg ? fact_cnt_inc : COUNT_BITS'(1);
                if (!factory_reg && fact_cnt_reg == COUNT_MAX)
                begin
                    fact_cnt_next = fact_cnt_inc;
                end
                if (CMP_BITS'(fact_cnt_next) >= CMP_BITS'(keepon_ticks_reg))
                begin
                    keep_on_next  = 1'b0;
                    fact_cnt_next = '0;
                end
            end
        end
    end

    // State update on each accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= LVL_GOOD;
            leds_reg     <= LED_OFF;
            trig_cnt_reg <= '0;
            sel_cnt_reg  <= '0;
            fact_cnt_reg <= '0;
            factory_reg  <= 1'b0;
            keep_on_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            level_reg    <= level_next;
            leds_reg     <= leds_next;
            trig_cnt_reg <= trig_cnt_next;
            sel_cnt_reg  <= sel_cnt_next;
            fact_cnt_reg <= fact_cnt_next;
            factory_reg  <= factory_next;
            keep_on_reg  <= keep_on_next;
        end
    end

    // Result register: loads with each accepted beat, holds while stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            res_level_reg   <= LVL_GOOD;
            res_leds_reg    <= LED_OFF;
            res_start_reg   <= 1'b0;
            res_keep_on_reg <= 1'b0;
            res_laser_reg   <= 1'b0;
            res_factory_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
            if (in_valid)
            begin
                res_level_reg   <= level_next;
                res_leds_reg    <= leds_next;
                res_start_reg   <= start_next;
                res_keep_on_reg <= keep_on_next;
                res_laser_reg   <= laser_next;
                res_factory_reg <= factory_next;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign battery_level    = res_level_reg;
    assign led_green        = res_leds_reg[0];
    assign led_blue         = res_leds_reg[1];
    assign led_red          = res_leds_reg[2];
    assign start_conversion = res_start_reg;
    assign keep_on          = res_keep_on_reg;
    assign laser_off_pulse  = res_laser_reg;
    assign factory_mode     = res_factory_reg;

endmodule

// ----- design/blm_checker.sv -----
// ----------------------------------------------------------------------------
// blm_checker
// Port-level checks on the result channel of the battery level monitor.
// ----------------------------------------------------------------------------
module blm_checker
    import blm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] battery_level,
    input logic       led_green,
    input logic       led_blue,
    input logic       led_red,
    input logic       start_conversion,
    input logic       keep_on,
    input logic       laser_off_pulse,
    input logic       factory_mode
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(battery_level) &&
        $stable(keep_on) && $stable(factory_mode) && $stable(laser_off_pulse))
        else $error("result beat changed while stalled");

    // The entry beat shows manufacturing mode with the low-level pattern.
    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && laser_off_pulse |-> factory_mode &&
        battery_level == LVL_LOW && led_green && !led_blue && led_red)
        else $error("manufacturing entry beat inconsistent");

    // A conversion request goes with a level pattern, never the charging one.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && start_conversion |-> led_blue || led_red)
        else $error("conversion requested with no level pattern shown");

    // Manufacturing mode never clears once shown.
    a_latch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && factory_mode |=> factory_mode)
        else $error("manufacturing mode cleared");

    // Keep-on is only ever raised by manufacturing entry.
    a_keep_on: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && keep_on |-> factory_mode)
        else $error("keep-on set outside manufacturing mode");

endmodule

bind battery_level_monitor blm_checker u_blm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .battery_level    (battery_level),
    .led_green        (led_green),
    .led_blue         (led_blue),
    .led_red          (led_red),
    .start_conversion (start_conversion),
    .keep_on          (keep_on),
    .laser_off_pulse  (laser_off_pulse),
    .factory_mode     (factory_mode)
);
